// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/pfis_pkg.sv =====
// Types, constants and helpers of the function bring-up sequencer.
`timescale 1ns / 1ps
package pfis_pkg;

    localparam int BAR_COUNT = 6;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_EP   = 2'd1;
    localparam logic [1:0] ST_NOT_32   = 2'd2;
    localparam logic [1:0] ST_BAD_BAR  = 2'd3;

    localparam logic [7:0] OFF_HDR = 8'h0E;
    localparam logic [7:0] OFF_CMD = 8'h04;
    localparam logic [7:0] OFF_IRQ = 8'h3C;
    localparam logic [7:0] OFF_BAR0 = 8'h10;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_HDR     = 9'b000000010,
        PH_CMD     = 9'b000000100,
        PH_BAR     = 9'b000001000,
        PH_ONES    = 9'b000010000,
        PH_SIZE    = 9'b000100000,
        PH_RESTORE = 9'b001000000,
        PH_IRQ     = 9'b010000000,
        PH_FAIL    = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] config_address;
        logic [31:0] write_data;
        logic [2:0]  bar_index;
        logic        bar_is_memory;
        logic [31:0] bar_base;
        logic [31:0] bar_size;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // One accepted input item expands into zero to three result beats.
    typedef struct packed {
        logic [1:0]      cnt;
        res_t [2:0]      item;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [31:0] cfg_addr(input logic [7:0] bus, input logic [4:0] dev,
                                             input logic [2:0] fn, input logic [7:0] off);
        cfg_addr = {1'b1, 7'd0, bus, dev, fn, off[7:2], 2'b00};
    endfunction

    function automatic logic [7:0] bar_off(input logic [2:0] idx);
        bar_off = OFF_BAR0 + {3'd0, idx, 2'b00};
    endfunction

    function automatic res_t mk_req(input logic [1:0] kind, input logic [31:0] addr,
                                    input logic [31:0] wdata);
        res_t r;
        r = '0;
        r.kind = kind;
        r.config_address = addr;
        r.write_data = wdata;
        mk_req = r;
    endfunction

    function automatic res_t mk_report(input logic [2:0] idx, input logic mem,
                                       input logic [31:0] base, input logic [31:0] size);
        res_t r;
        r = '0;
        r.kind = KIND_REPORT;
        r.bar_index = idx;
        r.bar_is_memory = mem;
        r.bar_base = base;
        r.bar_size = size;
        mk_report = r;
    endfunction

    function automatic res_t mk_finish(input logic [1:0] st);
        res_t r;
        r = '0;
        r.kind = KIND_FINISH;
        r.status = st;
        r.last = 1'b1;
        mk_finish = r;
    endfunction

endpackage

// ===== rtl/core/pfis_front.sv =====
// Front end: accepts items, steps the bring-up sequence and builds result records.
`timescale 1ns / 1ps
module pfis_front
    import pfis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        opcode,
    input  logic [7:0]  bus_number,
    input  logic [4:0]  device_number,
    input  logic [2:0]  function_number,
    input  logic [31:0] read_data,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output logic        push,
    output rec_t        rec
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  bus_reg, bus_next;
    logic [4:0]  dev_reg, dev_next;
    logic [2:0]  fn_reg, fn_next;
    logic [2:0]  bar_reg, bar_next;
    logic [31:0] orig_reg, orig_next;
    logic [31:0] sized_reg, sized_next;
    logic [1:0]  fail_reg, fail_next;
    logic [7:0]  irq_reg;

    logic [2:0]  nb;
    logic [31:0] cur_bar_addr;
    logic [31:0] cmd_addr;
    logic [31:0] base;
    res_t        nb_req;
    phase_t      nb_phase;

    always_comb
    begin
        nb = bar_reg + 3'd1;
        cur_bar_addr = cfg_addr(bus_reg, dev_reg, fn_reg, bar_off(bar_reg));
        cmd_addr = cfg_addr(bus_reg, dev_reg, fn_reg, OFF_CMD);
        base = orig_reg & 32'hFFFFFFF0;
        if (32'(nb) < BAR_COUNT)
        begin
            nb_phase = PH_BAR;
            nb_req = mk_req(KIND_READ, cfg_addr(bus_reg, dev_reg, fn_reg, bar_off(nb)), '0);
        end
        else
        begin
            nb_phase = PH_IRQ;
            nb_req = mk_req(KIND_READ, cfg_addr(bus_reg, dev_reg, fn_reg, OFF_IRQ), '0);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bus_next = bus_reg;
        dev_next = dev_reg;
        fn_next = fn_reg;
        bar_next = bar_reg;
        orig_next = orig_reg;
        sized_next = sized_reg;
        fail_next = fail_reg;
        rec = '0;
        if (opcode == OP_START)
        begin
            bus_next = bus_number;
            dev_next = device_number;
            fn_next = function_number;
            bar_next = '0;
            fail_next = ST_OK;
            phase_next = PH_HDR;
            rec.cnt = 2'd1;
            rec.item[0] = mk_req(KIND_READ,
                cfg_addr(bus_number, device_number, function_number, OFF_HDR), '0);
        end
        else
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    rec.cnt = 2'd1;
                    rec.item[0] = mk_req(KIND_READ, cmd_addr, '0);
                    if (read_data[22:16] != 7'd0)
                    begin
                        fail_next = ST_NOT_EP;
                        phase_next = PH_FAIL;
                    end
                    else
                        phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    rec.cnt = 2'd2;
                    rec.item[0] = mk_req(KIND_WRITE, cmd_addr,
                                         {read_data[31:16], 16'h0007});
                    bar_next = '0;
                    phase_next = PH_BAR;
                    rec.item[1] = mk_req(KIND_READ,
                        cfg_addr(bus_reg, dev_reg, fn_reg, OFF_BAR0), '0);
                end
                PH_BAR:
                begin
                    orig_next = read_data;
                    if (read_data[0])
                    begin
                        rec.cnt = 2'd2;
                        rec.item[0] = mk_report(bar_reg, 1'b0,
                                                read_data & 32'hFFFFFFFC, '0);
                        rec.item[1] = nb_req;
                        bar_next = nb;
                        phase_next = nb_phase;
                    end
                    else if (read_data[2:1] != 2'd0)
                    begin
                        rec.cnt = 2'd1;
                        rec.item[0] = mk_req(KIND_READ, cmd_addr, '0);
                        fail_next = ST_NOT_32;
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        rec.cnt = 2'd1;
                        rec.item[0] = mk_req(KIND_READ, cur_bar_addr, '0);
                        phase_next = PH_ONES;
                    end
                end
                PH_ONES:
                begin
                    rec.cnt = 2'd2;
                    rec.item[0] = mk_req(KIND_WRITE, cur_bar_addr, 32'hFFFFFFFF);
                    rec.item[1] = mk_req(KIND_READ, cur_bar_addr, '0);
                    phase_next = PH_SIZE;
                end
                PH_SIZE:
                begin
                    sized_next = 32'd0 - (read_data & 32'hFFFFFFF0);
                    rec.cnt = 2'd1;
                    rec.item[0] = mk_req(KIND_READ, cur_bar_addr, '0);
                    phase_next = PH_RESTORE;
                end
                PH_RESTORE:
                begin
                    rec.item[0] = mk_req(KIND_WRITE, cur_bar_addr, orig_reg);
                    // A zero base with a nonzero size cannot be decoded.
                    if (base == 32'd0 && sized_reg != 32'd0)
                    begin
                        rec.cnt = 2'd2;
                        rec.item[1] = mk_req(KIND_READ, cmd_addr, '0);
                        fail_next = ST_BAD_BAR;
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        rec.cnt = 2'd3;
                        rec.item[1] = mk_report(bar_reg, 1'b1, base, sized_reg);
                        rec.item[2] = nb_req;
                        bar_next = nb;
                        phase_next = nb_phase;
                    end
                end
                PH_IRQ:
                begin
                    rec.cnt = 2'd2;
                    rec.item[0] = mk_req(KIND_WRITE,
                        cfg_addr(bus_reg, dev_reg, fn_reg, OFF_IRQ),
                        {read_data[31:8], irq_reg});
                    rec.item[1] = mk_finish(ST_OK);
                    phase_next = PH_IDLE;
                end
                PH_FAIL:
                begin
                    rec.cnt = 2'd2;
                    rec.item[0] = mk_req(KIND_WRITE, cmd_addr,
                                         {read_data[31:16], 16'h0200});
                    rec.item[1] = mk_finish(fail_reg);
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    rec.cnt = 2'd0;
                end
            endcase
        end
    end

    assign push = accept && (rec.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bus_reg <= '0;
            dev_reg <= '0;
            fn_reg <= '0;
            bar_reg <= '0;
            orig_reg <= '0;
            sized_reg <= '0;
            fail_reg <= '0;
            irq_reg <= 8'd11;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                bus_reg <= bus_next;
                dev_reg <= dev_next;
                fn_reg <= fn_next;
                bar_reg <= bar_next;
                orig_reg <= orig_next;
                sized_reg <= sized_next;
                fail_reg <= fail_next;
            end
            if (cfg_we)
                irq_reg <= cfg_data;
        end
    end

endmodule

// ===== rtl/core/pfis_queue.sv =====
// Two-entry queue of result records between the front and back ends.
`timescale 1ns / 1ps
module pfis_queue
    import pfis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  rec_t    wr_rec,
    input  logic    pop,
    output rec_t    rd_rec,
    output q_stat_t stat
);

    rec_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign stat.full = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign rd_rec = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/pfis_back.sv =====
// Back end: walks the beats of each queued record into the output register.
`timescale 1ns / 1ps
module pfis_back
    import pfis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  rec_t head,
    input  logic q_empty,
    output logic pop,
    input  logic out_ready,
    output logic out_valid,
    output res_t out_item
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    res_t       item_reg;
    logic       load;

    assign load = !q_empty && (!valid_reg || out_ready);
    assign pop = load && (idx_reg == head.cnt - 2'd1);
    assign out_valid = valid_reg;
    assign out_item = item_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= head.item[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            if (pop)
                idx_reg <= 2'd0;
            else if (load)
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/core/pci_function_init_sequencer_top.sv =====
// Bring-up sequencer for one PCI function over configuration mechanism one.
// Accepts one input beat per cycle whenever the two-entry record queue has room;
// each beat yields zero to three output beats, sent from the output register
// one per cycle while m_tready is high, so a stalled output stalls input once
// the queue is full. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pci_function_init_sequencer_top
    import pfis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bus_number[7:0], device_number[12:8], function_number[15:13], read_data[47:16]
    input  logic [47:0]  s_tdata,
    // opcode[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // config_address[31:0], write_data[63:32], bar_index[66:64], bar_is_memory[67],
    // bar_base[99:68], bar_size[131:100], status[133:132], zero[135:134]
    output logic [135:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);

    logic    accept, push, pop;
    rec_t    wr_rec, rd_rec;
    q_stat_t qs;
    res_t    item;

    assign s_tready = !qs.full;
    assign accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    pfis_front u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept),
        .opcode(s_tuser), .bus_number(s_tdata[7:0]), .device_number(s_tdata[12:8]),
        .function_number(s_tdata[15:13]), .read_data(s_tdata[47:16]),
        .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
        .push(push), .rec(wr_rec)
    );

    pfis_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wr_rec(wr_rec),
        .pop(pop), .rd_rec(rd_rec), .stat(qs)
    );

    pfis_back u_back (
        .clk(clk), .rst_n(rst_n), .head(rd_rec), .q_empty(qs.empty), .pop(pop),
        .out_ready(m_tready), .out_valid(m_tvalid), .out_item(item)
    );

    assign m_tdata = {2'b00, item.status, item.bar_size, item.bar_base, item.bar_is_memory,
                      item.bar_index, item.write_data, item.config_address};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;

    `ASSERT_IMPLIES(a_last_is_finish, clk, rst_n, m_tvalid && m_tlast, m_tuser == KIND_FINISH)
    `ASSERT_IMPLIES(a_push_has_room, clk, rst_n, push, !qs.full)
    `ASSERT_NEVER(a_queue_flags, clk, rst_n, qs.full && qs.empty)
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, !qs.empty && rd_rec.cnt != 2'd0)

endmodule
